// File: hw/rtl/bra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_pkg: shared types and constants of the bitmap run allocator
// Command and status codes, the bitmap word geometry and the result record
// of the word scan unit.
// ----------------------------------------------------------------------------
package bra_pkg;

  // Bitmap word geometry. The map is stored as words of WORD_BITS bits.
  localparam int WORD_BITS = 32;
  localparam int LW        = $clog2(WORD_BITS);

  // Run length and run counter width. It covers the largest MAX_RUN.
  localparam int RUN_W = 11;

  // Commands.
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_TEST    = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_NO_SPACE     = 2'd1;
  localparam logic [1:0] ST_OUT_OF_RANGE = 2'd2;

  // Result of scanning one word for a fitting run.
  typedef struct packed {
    logic             hit;        // the run is complete somewhere in this word
    logic [LW-1:0]    pos;        // lowest bit at which the run is complete
    logic [RUN_W-1:0] carry_next; // clear bits at the top end of the scan so far
  } scan_res_t;

endpackage

// File: hw/rtl/bra_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_req_if: request channel of the bitmap run allocator
// Valid/ready channel carrying one command with its run description.
// ----------------------------------------------------------------------------
interface bra_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [9:0] start_req;
  logic [6:0] count;

  modport source (output valid, command, start_req, count, input ready);
  modport sink   (input valid, command, start_req, count, output ready);
endinterface

// File: hw/rtl/bra_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_rsp_if: result channel of the bitmap run allocator
// Valid/ready channel carrying the outcome of one request.
// ----------------------------------------------------------------------------
interface bra_rsp_if;
  logic       valid;
  logic       ready;
  logic [9:0] found_start;
  logic [1:0] status;
  logic       run_clear;

  modport source (output valid, found_start, status, run_clear, input ready);
  modport sink   (input valid, found_start, status, run_clear, output ready);
endinterface

// File: hw/rtl/bitmap_run_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_run_allocator: first-fit allocator of contiguous bit runs
// Keeps an occupancy bitmap and serves allocate, release and test requests
// on runs of consecutive bits.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Fields                                Transfer
//  request  in   command, start_req, count             valid & ready
//  result   out  found_start, status, run_clear        valid & ready
//
// The bitmap lives in a single-port-read, single-port-write word memory of
// MAP_BITS/32 words with a registered read. One shared word scan unit looks
// at one word per cycle for allocation; each word that the found run touches
// is then read and written back. Release reads and writes back each word of
// its run in the same way; test only reads the words of its run.
// Requests with a bad command or count finish without touching the memory.
// After reset a clearing pass zeroes every memory word; the request
// channel is not ready during it, nor while a request is in work.
// A finished result waits in the output register, and the next request is
// accepted while it waits; a stalled result only holds up the end of that
// next request.
//
module bitmap_run_allocator
  import bra_pkg::*;
#(
  parameter int MAP_BITS = 1024, // multiple of 32, from 64 to 1024
  parameter int MAX_RUN  = 64    // from 1 to 1024
)(
  input  logic          clk,
  input  logic          rst,
  bra_req_if.sink       request,
  bra_rsp_if.source     result
);

  // Memory geometry and position widths.
  localparam int WORDS = MAP_BITS / WORD_BITS;
  localparam int WAW   = $clog2(WORDS);
  localparam int AW    = $clog2(MAP_BITS);
  localparam int PW    = (AW + 1 > 11) ? AW + 1 : 11;

  // Sequencer states.
  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_RRD  = 3'd3;
  localparam logic [2:0] S_RWR  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]       state;
  logic [2:0]       state_next;

  // Request under work.
  logic [1:0]       cmd_r;
  logic [RUN_W-1:0] cnt_r;
  logic [PW-1:0]    lo;
  logic [PW-1:0]    hi_m1;
  logic [WAW-1:0]   word_idx;

  // Scan pipeline: issue runs one read ahead of evaluation.
  logic [WAW:0]     issue_idx;
  logic [WAW-1:0]   eval_idx;
  logic             pend;
  logic [RUN_W-1:0] carry;

  // Clearing pass.
  logic [WAW-1:0]   init_row;

  // Result being built, and the output register.
  logic [9:0]       found_r;
  logic [1:0]       status_r;
  logic             clear_r;
  logic             out_valid;
  logic [9:0]       out_found;
  logic [1:0]       out_status;
  logic             out_clear;

  // Bitmap memory.
  logic [WORD_BITS-1:0] map_mem [WORDS];
  logic [WORD_BITS-1:0] rd_data;
  logic                 rd_en;
  logic [WAW-1:0]       rd_addr;
  logic                 wr_en;
  logic [WAW-1:0]       wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  // Decode of the incoming request.
  logic             accept;
  logic [RUN_W-1:0] req_cnt;
  logic [PW-1:0]    req_end;
  logic             cnt_bad;

  // Range walk helpers.
  logic [WAW-1:0]       lo_word;
  logic [WAW-1:0]       hi_word;
  logic [LW-1:0]        lo_off;
  logic [LW-1:0]        hi_off;
  logic [WORD_BITS-1:0] mask;

  // Scan helpers.
  scan_res_t        scan;
  logic [PW-1:0]    hit_end;
  logic [PW-1:0]    hit_start;
  logic             load_out;

  assign accept  = request.valid && request.ready;
  assign req_cnt = RUN_W'(request.count);
  assign req_end = PW'(request.start_req) + PW'(request.count);
  assign cnt_bad = (req_cnt == '0) || (req_cnt > RUN_W'(MAX_RUN));

  assign request.ready = (state == S_IDLE);

  assign result.valid       = out_valid;
  assign result.found_start = out_found;
  assign result.status      = out_status;
  assign result.run_clear   = out_clear;

  bra_word_scan u_scan (
    .word  (rd_data),
    .cnt   (cnt_r),
    .carry (carry),
    .res   (scan)
  );

  // The run ends at the hit bit, so its last position is the word base plus
  // the hit offset; its start lies count-1 positions below.
  assign hit_end   = PW'({eval_idx, scan.pos});
  assign hit_start = hit_end + PW'(1) - PW'(cnt_r);

  // Bits of the current word that lie inside [lo, hi_m1].
  assign lo_word = lo[LW +: WAW];
  assign hi_word = hi_m1[LW +: WAW];
  assign lo_off  = (word_idx == lo_word) ? lo[LW-1:0] : '0;
  assign hi_off  = (word_idx == hi_word) ? hi_m1[LW-1:0] : LW'(WORD_BITS - 1);
  assign mask    = ({WORD_BITS{1'b1}} << lo_off) &
                   ({WORD_BITS{1'b1}} >> (LW'(WORD_BITS - 1) - hi_off));

  // Memory port control.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = word_idx;
    wr_en   = 1'b0;
    wr_addr = word_idx;
    wr_data = rd_data | mask;
    case (state)
      S_INIT: begin
        wr_en   = 1'b1;
        wr_addr = init_row;
        wr_data = '0;
      end
      S_SCAN: begin
        rd_en   = (issue_idx < (WAW + 1)'(WORDS));
        rd_addr = issue_idx[WAW-1:0];
      end
      S_RRD: begin
        rd_en = 1'b1;
      end
      S_RWR: begin
        wr_en   = (cmd_r != CMD_TEST);
        wr_data = (cmd_r == CMD_RELEASE) ? (rd_data & ~mask) : (rd_data | mask);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= map_mem[rd_addr];
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (init_row == WAW'(WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (cnt_bad) begin
            state_next = S_DONE;
          end else begin
            case (request.command)
              CMD_ALLOC: begin
                state_next = (PW'(request.count) > PW'(MAP_BITS)) ? S_DONE : S_SCAN;
              end
              CMD_RELEASE, CMD_TEST: begin
                state_next = (req_end > PW'(MAP_BITS)) ? S_DONE : S_RRD;
              end
              default: begin
                state_next = S_DONE;
              end
            endcase
          end
        end
      end
      S_SCAN: begin
        if (pend) begin
          if (scan.hit) begin
            state_next = S_RRD;
          end else if (eval_idx == WAW'(WORDS - 1)) begin
            state_next = S_DONE;
          end
        end
      end
      S_RRD: begin
        state_next = S_RWR;
      end
      S_RWR: begin
        state_next = (word_idx == hi_word) ? S_DONE : S_RRD;
      end
      S_DONE: begin
        if (!out_valid || result.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  assign load_out = (state == S_DONE) && (!out_valid || result.ready);

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      init_row  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_INIT) begin
        init_row <= init_row + WAW'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Work registers of the request in progress.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd_r     <= request.command;
          cnt_r     <= req_cnt;
          lo        <= PW'(request.start_req);
          hi_m1     <= req_end - PW'(1);
          word_idx  <= request.start_req[LW +: WAW];
          issue_idx <= '0;
          eval_idx  <= '0;
          pend      <= 1'b0;
          carry     <= '0;
          found_r   <= '0;
          clear_r   <= (request.command == CMD_TEST);
          status_r  <= ST_OK;
          if (cnt_bad) begin
            status_r <= ST_OUT_OF_RANGE;
            clear_r  <= 1'b0;
          end else begin
            case (request.command)
              CMD_ALLOC: begin
                if (PW'(request.count) > PW'(MAP_BITS)) begin
                  status_r <= ST_NO_SPACE;
                end
              end
              CMD_RELEASE, CMD_TEST: begin
                if (req_end > PW'(MAP_BITS)) begin
                  status_r <= ST_OUT_OF_RANGE;
                  clear_r  <= 1'b0;
                end
              end
              default: begin
                status_r <= ST_OUT_OF_RANGE;
              end
            endcase
          end
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          issue_idx <= issue_idx + (WAW + 1)'(1);
        end
        pend <= rd_en;
        if (pend) begin
          eval_idx <= eval_idx + WAW'(1);
          carry    <= scan.carry_next;
          if (scan.hit) begin
            lo       <= hit_start;
            hi_m1    <= hit_end;
            word_idx <= hit_start[LW +: WAW];
            found_r  <= 10'(hit_start);
          end else if (eval_idx == WAW'(WORDS - 1)) begin
            status_r <= ST_NO_SPACE;
          end
        end
      end
      S_RWR: begin
        if ((cmd_r == CMD_TEST) && ((rd_data & mask) != '0)) begin
          clear_r <= 1'b0;
        end
        word_idx <= word_idx + WAW'(1);
      end
      default: begin
        carry <= carry;
      end
    endcase
    if (load_out) begin
      out_found  <= found_r;
      out_status <= status_r;
      out_clear  <= clear_r;
    end
  end

`ifndef NO_ASSERTIONS
  // A failed outcome never carries a start or a clear flag.
  a_fail_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.status != ST_OK)) |->
      ((result.found_start == '0) && (result.run_clear == 1'b0)))
    else $error("failed request carries a start or a clear flag");

  // The evaluated word always trails the issued read by exactly one.
  a_scan_order: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && pend) |->
      (issue_idx == ((WAW + 1)'(eval_idx) + (WAW + 1)'(1))))
    else $error("scan evaluation out of step with reads");

  // The range walk stays inside the words of the run.
  a_walk_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_RWR) |-> ((word_idx >= lo_word) && (word_idx <= hi_word)))
    else $error("range walk left the run");

  // A new result appears only from the completion state.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> ($past(state) == S_DONE))
    else $error("result raised outside completion");

  // The memory is never written while the scan reads it.
  a_scan_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !wr_en)
    else $error("bitmap written during scan");
`endif

endmodule

// File: hw/rtl/bra_word_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_word_scan: first-fit search over one bitmap word
// Given the clear bits carried in from lower words, finds the lowest bit at
// which a clear run of the requested length completes.
// ----------------------------------------------------------------------------
module bra_word_scan
  import bra_pkg::*;
(
  input  logic [WORD_BITS-1:0] word,
  input  logic [RUN_W-1:0]     cnt,
  input  logic [RUN_W-1:0]     carry,
  output scan_res_t            res
);

  logic [WORD_BITS-1:0] clr;
  logic [WORD_BITS-1:0] pj;
  logic [WORD_BITS-1:0] a_vec;
  logic [WORD_BITS-1:0] b_vec;
  logic [WORD_BITS-1:0] hit_vec;
  logic [RUN_W-1:0]     need;
  logic [RUN_W-1:0]     top_clr;
  logic [LW-1:0]        pos;
  int                   off;

  // Runs lying wholly inside the word: build masks of clear runs of each
  // power-of-two length, then chain the ones that make up cnt.
  always_comb begin
    clr   = ~word;
    pj    = clr;
    a_vec = '1;
    off   = 0;
    for (int j = 0; j <= LW; j++) begin
      if (j > 0) begin
        pj = pj & (pj << (1 << (j - 1)));
      end
      if (cnt[j]) begin
        a_vec = a_vec & (pj << off);
        off   = off + (1 << j);
      end
    end
    if (cnt > RUN_W'(WORD_BITS)) begin
      a_vec = '0;
    end
  end

  // Runs that reach down to bit 0 and continue into lower words.
  assign need = cnt - carry - RUN_W'(1);

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      b_vec[i] = ((word & ({WORD_BITS{1'b1}} >> (WORD_BITS - 1 - i))) == '0) &&
                 (RUN_W'(i) >= need);
    end
  end

  assign hit_vec = a_vec | b_vec;

  always_comb begin
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        pos = LW'(i);
      end
    end
  end

  // Clear bits above the highest marked bit.
  always_comb begin
    top_clr = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (word[i]) begin
        top_clr = RUN_W'(WORD_BITS - 1 - i);
      end
    end
  end

  assign res.hit        = |hit_vec;
  assign res.pos        = pos;
  assign res.carry_next = (word == '0) ? (carry + RUN_W'(WORD_BITS)) : top_clr;

endmodule

// File: tb/tb_bitmap_run_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_run_allocator: self-checking bench of the bitmap run allocator
// Drives allocate, release and test requests through the request channel. A
// scoreboard keeps its own copy of the occupancy map, predicts each outcome
// and compares it field by field with the result channel, in order.
// ----------------------------------------------------------------------------
module tb_bitmap_run_allocator;
  import bra_pkg::*;

  localparam int MAP_BITS     = 1024;
  localparam int MAX_RUN      = 64;
  localparam int RANDOM_ITEMS = 550;
  // Cycles of silence on both channels before the run is declared hung. This
  // leaves a wide margin over the long result hold-off below.
  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 400;
  // Drain time after the last expected result.
  localparam int SETTLE_CYCLES = 80;

  // The package names three commands; the fourth encoding is illegal and
  // must come back as out_of_range.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [9:0] found_start;
    logic [1:0] status;
    logic       run_clear;
  } alloc_outcome_t;

  typedef struct {
    int first;
    int len;
  } run_span_t;

  // Scoreboard. It owns a private occupancy map that follows every accepted
  // request, and a queue of outcomes still owed by the block. It also lists
  // the runs it has seen granted, so the stimulus can free real allocations.
  class alloc_scoreboard;
    bit [MAP_BITS-1:0] occupancy;
    alloc_outcome_t    outcome_q[$];
    run_span_t         granted_runs[$];
    int                errors;

    function new();
      occupancy = '0;
      errors    = 0;
    endfunction

    function void note_request(logic [1:0] cmd, logic [9:0] start, logic [6:0] cnt);
      alloc_outcome_t res;
      int             run;
      int             first;
      int             i;
      bit             hit;
      res   = '0;
      run   = 0;
      first = 0;
      hit   = 1'b0;
      if (cmd == CMD_UNUSED || cnt == 0 || int'(cnt) > MAX_RUN) begin
        res.status = ST_OUT_OF_RANGE;
      end else if (cmd == CMD_ALLOC) begin
        // First fit: walk up from bit 0 counting clear bits in a row and stop
        // as soon as the row is long enough.
        for (i = 0; i < MAP_BITS && !hit; i++) begin
          run = occupancy[i] ? 0 : run + 1;
          if (run == int'(cnt)) begin
            first = i + 1 - int'(cnt);
            hit   = 1'b1;
          end
        end
        if (hit) begin
          for (i = first; i < first + int'(cnt); i++) occupancy[i] = 1'b1;
          res.found_start = 10'(first);
          granted_runs.push_back('{first, int'(cnt)});
        end else begin
          res.status = ST_NO_SPACE;
        end
      end else if (int'(start) + int'(cnt) > MAP_BITS) begin
        res.status = ST_OUT_OF_RANGE;
      end else if (cmd == CMD_RELEASE) begin
        for (i = int'(start); i < int'(start) + int'(cnt); i++) occupancy[i] = 1'b0;
      end else begin
        res.run_clear = 1'b1;
        for (i = int'(start); i < int'(start) + int'(cnt); i++)
          if (occupancy[i]) res.run_clear = 1'b0;
      end
      outcome_q.push_back(res);
    endfunction

    task report_mismatch(string what);
      $display("tb: %0t ns: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [9:0] found, logic [1:0] status, logic clear);
      alloc_outcome_t want;
      if (outcome_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result found_start=%0d status=%0d run_clear=%0b",
                                  found, status, clear));
        return;
      end
      want = outcome_q.pop_front();
      if (found !== want.found_start)
        report_mismatch($sformatf("found_start %0d, predicted %0d", found, want.found_start));
      if (status !== want.status)
        report_mismatch($sformatf("status %0d, predicted %0d", status, want.status));
      if (clear !== want.run_clear)
        report_mismatch($sformatf("run_clear %0b, predicted %0b", clear, want.run_clear));
    endtask
  endclass

  logic clk;
  logic rst;

  bra_req_if request();
  bra_rsp_if result();

  bitmap_run_allocator #(
    .MAP_BITS (MAP_BITS),
    .MAX_RUN  (MAX_RUN)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .result  (result)
  );

  alloc_scoreboard sb = new();

  // Set by the request side. hold_results asks the result side for one long
  // hold-off; steady_flow switches idling off on both sides for a stretch.
  bit hold_results = 1'b0;
  bit steady_flow  = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Idle length for either side: mostly none or a few cycles, now and then a
  // long one so that gaps land on every phase of a scan.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Run lengths lean short so the map fragments, with the full MAX_RUN now
  // and then.
  function automatic logic [6:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 7'($urandom_range(1, 16));
    if (r < 95) return 7'($urandom_range(17, MAX_RUN));
    return 7'(MAX_RUN);
  endfunction

  // Offers one request and returns at the edge where it is taken. When there
  // is no gap, valid simply stays high from the previous request.
  task send_request(logic [1:0] cmd, logic [9:0] start, logic [6:0] cnt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      request.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request.valid     <= 1'b1;
    request.command   <= cmd;
    request.start_req <= start;
    request.count     <= cnt;
    @(posedge clk);
    while (!request.ready) @(posedge clk);
    sb.note_request(cmd, start, cnt);
  endtask

  // One random request. Most are well formed: allocations, releases of runs
  // that were really granted, and tests of granted or random runs. The rest
  // are in-range noise and malformed requests. release_heavy tilts the mix so
  // the map swings between nearly full and nearly empty.
  task random_request(bit release_heavy);
    int          r;
    int          k;
    int          alloc_share;
    run_span_t   span;
    logic [1:0]  cmd;
    logic [9:0]  start;
    logic [6:0]  cnt;
    alloc_share = release_heavy ? 25 : 55;
    r     = $urandom_range(0, 99);
    cmd   = CMD_ALLOC;
    start = 10'($urandom_range(0, MAP_BITS - 1));
    cnt   = pick_len();
    if (r < alloc_share || (r < 80 && sb.granted_runs.size() == 0)) begin
      cmd = CMD_ALLOC;
    end else if (r < 80) begin
      k     = $urandom_range(0, sb.granted_runs.size() - 1);
      span  = sb.granted_runs[k];
      start = 10'(span.first);
      cnt   = 7'(span.len);
      if ($urandom_range(0, 3) == 0) begin
        cmd = CMD_TEST;
      end else begin
        cmd = CMD_RELEASE;
        sb.granted_runs.delete(k);
      end
    end else if (r < 90) begin
      cmd   = $urandom_range(0, 1) ? CMD_RELEASE : CMD_TEST;
      start = 10'($urandom_range(0, MAP_BITS - int'(cnt)));
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          cmd = 2'($urandom_range(0, 3));
          cnt = 7'd0;
        end
        1: begin
          cmd = 2'($urandom_range(0, 3));
          cnt = 7'($urandom_range(MAX_RUN + 1, 127));
        end
        2: begin
          cmd = CMD_UNUSED;
        end
        default: begin
          // A release or test whose run hangs over the top of the map.
          cmd   = $urandom_range(0, 1) ? CMD_RELEASE : CMD_TEST;
          cnt   = 7'($urandom_range(2, MAX_RUN));
          start = 10'($urandom_range(MAP_BITS - int'(cnt) + 1, MAP_BITS - 1));
        end
      endcase
    end
    send_request(cmd, start, cnt);
  endtask

  // Result side: random stalls, plus one long hold-off on request. During the
  // hold-off the request side keeps offering, so the block parks one result,
  // takes one more request and then has to stall its input.
  initial begin : result_side
    int stall;
    result.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_results) begin
        result.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          result.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        result.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Every result taken by the bench is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && result.valid && result.ready)
      sb.check_result(result.found_start, result.status, result.run_clear);
  end

  // Hang detection: counts edges with no transfer on either channel.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((request.valid && request.ready) || (result.valid && result.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("bitmap_run_allocator: mismatch");
    $finish;
  end

  initial begin : stimulus
    int n;
    rst               <= 1'b1;
    request.valid     <= 1'b0;
    request.command   <= CMD_ALLOC;
    request.start_req <= '0;
    request.count     <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part. A single bit at 0, then fifteen full-size runs stacked
    // above it leave 63 bits at the top, so the next full-size request finds
    // no fitting run while one of 63 lands at the very end of the map.
    send_request(CMD_ALLOC, 10'h3FF, 7'd1);
    for (n = 0; n < 15; n++) send_request(CMD_ALLOC, 10'($urandom), 7'(MAX_RUN));
    send_request(CMD_ALLOC, 10'd0, 7'(MAX_RUN));
    send_request(CMD_ALLOC, 10'd0, 7'd63);
    send_request(CMD_TEST, 10'd0, 7'(MAX_RUN));
    // Free the last bit of the map and take it back with a one-bit request,
    // which returns the highest possible start.
    send_request(CMD_RELEASE, 10'h3FF, 7'd1);
    send_request(CMD_ALLOC, 10'd0, 7'd1);
    // The second release hits bits that are already clear.
    send_request(CMD_RELEASE, 10'd512, 7'(MAX_RUN));
    send_request(CMD_RELEASE, 10'd512, 7'(MAX_RUN));
    send_request(CMD_TEST, 10'd512, 7'(MAX_RUN));
    // Runs that reach past the end of the map.
    send_request(CMD_RELEASE, 10'd961, 7'(MAX_RUN));
    send_request(CMD_TEST, 10'h3FF, 7'd2);
    // Bad counts on allocate and test, and the unused command encoding.
    send_request(CMD_ALLOC, 10'd0, 7'd0);
    send_request(CMD_ALLOC, 10'd0, 7'(MAX_RUN + 1));
    send_request(CMD_TEST, 10'd0, 7'h7F);
    send_request(CMD_UNUSED, 10'd5, 7'd8);

    // Random part. The mix alternates every hundred requests, starting with
    // releases since the directed part left the map almost full.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      steady_flow = (n >= 195 && n < 230) || (n >= 400 && n < 460);
      if (n == 200) hold_results = 1'b1;
      random_request((n / 100) % 2 == 0);
    end
    request.valid <= 1'b0;

    while (sb.outcome_q.size() != 0) @(posedge clk);
    // Any stray result after the last expected one is caught by the checker.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outcome_q.size() == 0)
      $display("bitmap_run_allocator: match");
    else
      $display("bitmap_run_allocator: mismatch");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/bra_pkg.sv
hw/rtl/bra_req_if.sv
hw/rtl/bra_rsp_if.sv
hw/rtl/bra_word_scan.sv
hw/rtl/bitmap_run_allocator.sv
tb/tb_bitmap_run_allocator.sv
